@@ src/vrpva_pkg.sv @@
package vrpva_pkg;

	localparam int PatternBytes = 8192;
	localparam int NametableBytes = 1024;
	localparam int PaletteEntries = 32;
	localparam int SpriteBytes = 256;

	localparam int PatAw = $clog2(PatternBytes);
	localparam int NtAw = $clog2(2 * NametableBytes);
	localparam int PalAw = $clog2(PaletteEntries);
	localparam int SprAw = $clog2(SpriteBytes);

	localparam logic [2:0] RegControl = 3'd0;
	localparam logic [2:0] RegMask = 3'd1;
	localparam logic [2:0] RegStatus = 3'd2;
	localparam logic [2:0] RegSprAddr = 3'd3;
	localparam logic [2:0] RegSprData = 3'd4;
	localparam logic [2:0] RegScroll = 3'd5;
	localparam logic [2:0] RegAddr = 3'd6;
	localparam logic [2:0] RegData = 3'd7;

	localparam logic OpRead = 1'b0;
	localparam logic OpWrite = 1'b1;

	localparam logic [2:0] StatusReset = 3'b101;
	localparam logic [5:0] PaletteReset = 6'h3f;
	localparam logic [7:0] SpriteReset = 8'hff;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RG_PAT,
		RG_NT,
		RG_PAL
	} region_t;

	function automatic logic [PalAw-1:0] pal_index(input logic [15:0] a);
		logic [PalAw-1:0] i;
		i = a[PalAw-1:0];
		if ((i & 5'h13) == 5'h10) begin
			i = i & 5'h0f;
		end
		return i;
	endfunction

	function automatic logic [NtAw-1:0] nt_index(input logic [15:0] a, input logic vert);
		logic t;
		t = vert ? a[11] : a[10];
		return {t, a[9:0]};
	endfunction

	function automatic region_t region_of(input logic [15:0] a);
		region_t r;
		if (a[13:0] <= 14'h1fff) begin
			r = RG_PAT;
		end else if (a[13:0] < 14'h3f00) begin
			r = RG_NT;
		end else begin
			r = RG_PAL;
		end
		return r;
	endfunction

endpackage

@@ src/vrpva_if.sv @@
interface vrpva_req_if;
	logic valid;
	logic ready;
	logic op;
	logic [2:0] reg_index;
	logic [7:0] write_data;
	modport source(output valid, output op, output reg_index, output write_data, input ready);
	modport sink(input valid, input op, input reg_index, input write_data, output ready);
endinterface

interface vrpva_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] read_data;
	modport source(output valid, output read_data, input ready);
	modport sink(input valid, input read_data, output ready);
endinterface

@@ src/vrpva_ram.sv @@
module vrpva_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/video_register_port_vram_access_top.sv @@
// CPU register port of a tile video unit. Each request is one bus access to one of
// eight registers and gives one response byte. The cycle that takes a request reads
// the addressed memory (pattern, nametable, palette or sprite memory, each a
// synchronous RAM); the ST_DONE state then forms the response and writes back.
// A new request is taken only in ST_IDLE, once the previous one has left ST_DONE, and
// only while the output register is empty or its response is being accepted. After
// reset a clearing pass fills the pattern, nametable, palette and sprite memories with
// their reset values; requests are held off meanwhile, configuration writes are taken.
module video_register_port_vram_access_top (
	input logic clk,
	input logic arst_n,
	vrpva_req_if.sink req,
	vrpva_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic mirror_vertical_q;
	logic [7:0] control_q, mask_q, read_buffer_q, bus_latch_q, spr_ptr_q;
	logic [2:0] status_q, fine_x_q;
	logic [15:0] cur_addr_q, stg_addr_q;
	logic toggle_q;
	logic [vrpva_pkg::PatAw-1:0] clr_q;
	logic clearing_q;

	vrpva_pkg::state_t state_q, state_d;
	logic op_s1;
	logic [2:0] reg_s1;
	logic [7:0] wd_s1;
	logic out_valid_q;
	logic [7:0] out_data_q;

	// apb
	assign pready = 1'b1;
	assign prdata = {31'd0, mirror_vertical_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_vertical_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			mirror_vertical_q <= pwdata[0];
		end
	end

	logic take;
	assign req.ready = !clearing_q && state_q == vrpva_pkg::ST_IDLE &&
		(!out_valid_q || rsp.ready);
	assign take = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			vrpva_pkg::ST_IDLE: begin
				if (take) begin
					state_d = vrpva_pkg::ST_DONE;
				end
			end
			vrpva_pkg::ST_DONE: state_d = vrpva_pkg::ST_IDLE;
			default: state_d = vrpva_pkg::ST_IDLE;
		endcase
	end

	// memory reads in request cycle, addresses from current state
	logic [15:0] alt_addr;
	assign alt_addr = cur_addr_q & 16'h2fff;
	logic [vrpva_pkg::PatAw-1:0] pat_ra, pat_wa;
	logic [vrpva_pkg::NtAw-1:0] nt_ra, nt_ra2, nt_wa;
	logic [vrpva_pkg::PalAw-1:0] pal_ra, pal_wa;
	logic [7:0] pat_rd, nt_rd, spr_rd, pat_wd, nt_wd, spr_wd;
	logic [5:0] pal_rd, pal_wd;
	logic pat_we, nt_we, pal_we, spr_we;
	logic [7:0] spr_wa;
	vrpva_pkg::region_t rg;

	assign rg = vrpva_pkg::region_of(cur_addr_q);
	assign pat_ra = cur_addr_q[vrpva_pkg::PatAw-1:0];
	assign nt_ra2 = vrpva_pkg::nt_index(alt_addr, mirror_vertical_q);
	assign nt_ra = (rg == vrpva_pkg::RG_PAL) ? nt_ra2
		: vrpva_pkg::nt_index(cur_addr_q, mirror_vertical_q);
	assign pal_ra = vrpva_pkg::pal_index(cur_addr_q);

	vrpva_ram #(.Width(8), .Depth(vrpva_pkg::PatternBytes)) u_pat (
		.clk, .we(pat_we), .waddr(pat_wa), .wdata(pat_wd), .raddr(pat_ra), .rdata(pat_rd));
	vrpva_ram #(.Width(8), .Depth(2 * vrpva_pkg::NametableBytes)) u_nt (
		.clk, .we(nt_we), .waddr(nt_wa), .wdata(nt_wd), .raddr(nt_ra), .rdata(nt_rd));
	vrpva_ram #(.Width(6), .Depth(vrpva_pkg::PaletteEntries)) u_pal (
		.clk, .we(pal_we), .waddr(pal_wa), .wdata(pal_wd), .raddr(pal_ra), .rdata(pal_rd));
	vrpva_ram #(.Width(8), .Depth(vrpva_pkg::SpriteBytes)) u_spr (
		.clk, .we(spr_we), .waddr(spr_wa), .wdata(spr_wd), .raddr(spr_ptr_q), .rdata(spr_rd));

	logic do2;
	logic wr_data, wr_spr;
	assign do2 = state_q == vrpva_pkg::ST_DONE;
	assign wr_data = do2 && op_s1 == vrpva_pkg::OpWrite && reg_s1 == vrpva_pkg::RegData;
	assign wr_spr = do2 && op_s1 == vrpva_pkg::OpWrite && reg_s1 == vrpva_pkg::RegSprData;

	always_comb begin
		pat_we = clearing_q || (wr_data && rg == vrpva_pkg::RG_PAT);
		nt_we = clearing_q || (wr_data && rg == vrpva_pkg::RG_NT);
		pal_we = clearing_q || (wr_data && rg == vrpva_pkg::RG_PAL);
		spr_we = clearing_q || wr_spr;
		pat_wa = clearing_q ? clr_q : pat_ra;
		nt_wa = clearing_q ? clr_q[vrpva_pkg::NtAw-1:0]
			: vrpva_pkg::nt_index(cur_addr_q, mirror_vertical_q);
		pal_wa = clearing_q ? clr_q[vrpva_pkg::PalAw-1:0] : pal_ra;
		spr_wa = clearing_q ? clr_q[7:0] : spr_ptr_q;
		pat_wd = clearing_q ? 8'd0 : wd_s1;
		nt_wd = clearing_q ? 8'd0 : wd_s1;
		pal_wd = clearing_q ? vrpva_pkg::PaletteReset : wd_s1[5:0];
		spr_wd = clearing_q ? vrpva_pkg::SpriteReset : wd_s1;
	end

	// response and register update
	logic [7:0] vram_rd, r;
	logic [15:0] inc;
	always_comb begin
		case (rg)
			vrpva_pkg::RG_PAT: vram_rd = pat_rd;
			vrpva_pkg::RG_NT: vram_rd = nt_rd;
			default: vram_rd = {2'b00, pal_rd};
		endcase
		inc = control_q[2] ? 16'd32 : 16'd1;
		case (reg_s1)
			vrpva_pkg::RegStatus: r = {status_q, bus_latch_q[4:0]};
			vrpva_pkg::RegSprData: r = spr_rd;
			vrpva_pkg::RegData: r = (rg == vrpva_pkg::RG_PAL) ? vram_rd : read_buffer_q;
			default: r = bus_latch_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= req.op;
			reg_s1 <= req.reg_index;
			wd_s1 <= req.write_data;
		end
		if (do2) begin
			out_data_q <= (op_s1 == vrpva_pkg::OpWrite) ? 8'd0 : r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrpva_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			clearing_q <= 1'b1;
			clr_q <= '0;
			control_q <= '0;
			mask_q <= '0;
			status_q <= vrpva_pkg::StatusReset;
			cur_addr_q <= '0;
			stg_addr_q <= '0;
			fine_x_q <= '0;
			toggle_q <= 1'b0;
			read_buffer_q <= '0;
			bus_latch_q <= '0;
			spr_ptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (&clr_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (do2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (do2 && op_s1 == vrpva_pkg::OpWrite) begin
				bus_latch_q <= wd_s1;
				case (reg_s1)
					vrpva_pkg::RegControl: begin
						control_q <= wd_s1;
						stg_addr_q[11:10] <= wd_s1[1:0];
					end
					vrpva_pkg::RegMask: mask_q <= wd_s1;
					vrpva_pkg::RegSprAddr: spr_ptr_q <= wd_s1;
					vrpva_pkg::RegSprData: spr_ptr_q <= spr_ptr_q + 8'd1;
					vrpva_pkg::RegScroll: begin
						if (!toggle_q) begin
							fine_x_q <= wd_s1[2:0];
							stg_addr_q[4:0] <= wd_s1[7:3];
						end else begin
							stg_addr_q[14:12] <= wd_s1[2:0];
							stg_addr_q[9:5] <= wd_s1[7:3];
						end
						toggle_q <= !toggle_q;
					end
					vrpva_pkg::RegAddr: begin
						if (!toggle_q) begin
							stg_addr_q[15:8] <= {2'b00, wd_s1[5:0]};
						end else begin
							stg_addr_q[7:0] <= wd_s1;
							cur_addr_q <= {stg_addr_q[15:8], wd_s1};
						end
						toggle_q <= !toggle_q;
					end
					vrpva_pkg::RegData: cur_addr_q <= cur_addr_q + inc;
					default: ;
				endcase
			end else if (do2) begin
				bus_latch_q <= r;
				case (reg_s1)
					vrpva_pkg::RegStatus: begin
						status_q[2] <= 1'b0;
						toggle_q <= 1'b0;
					end
					vrpva_pkg::RegData: begin
						read_buffer_q <= (rg == vrpva_pkg::RG_PAL) ? nt_rd : vram_rd;
						cur_addr_q <= cur_addr_q + inc;
					end
					default: ;
				endcase
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_data = out_data_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q == vrpva_pkg::ST_DONE && !req.ready)
		else $error("request taken while busy");
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ##1 rsp.valid)
		else $error("response missing after request");
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req.ready)
		else $error("request taken during clearing pass");
	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do2 && op_s1 == vrpva_pkg::OpRead && reg_s1 == vrpva_pkg::RegStatus
		|=> !status_q[2] && !toggle_q)
		else $error("status read did not clear flags");
endmodule

@@ tb/video_register_port_vram_access_top_tb.sv @@
module video_register_port_vram_access_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	class port_scoreboard;
		bit mirror_vertical;
		logic [7:0] control_bits;
		logic [7:0] mask_bits;
		logic [2:0] status_top_bits;
		logic [15:0] current_address;
		logic [15:0] staged_address;
		logic [2:0] fine_scroll_x;
		bit write_toggle;
		logic [7:0] read_buffer;
		logic [7:0] bus_latch;
		logic [7:0] sprite_pointer;
		logic [7:0] sprite_mem [256];
		logic [7:0] nt_mem [2048];
		logic [5:0] pal_mem [32];
		logic [7:0] pat_mem [8192];
		logic [7:0] expected_bytes [$];
		int errors;
		int checked;

		function new();
			mirror_vertical = 0;
			control_bits = 0;
			mask_bits = 0;
			status_top_bits = 3'b101;
			current_address = 0;
			staged_address = 0;
			fine_scroll_x = 0;
			write_toggle = 0;
			read_buffer = 0;
			bus_latch = 0;
			sprite_pointer = 0;
			foreach (sprite_mem[i]) sprite_mem[i] = 8'hff;
			foreach (nt_mem[i]) nt_mem[i] = 8'h00;
			foreach (pal_mem[i]) pal_mem[i] = 6'h3f;
			foreach (pat_mem[i]) pat_mem[i] = 8'h00;
			errors = 0;
			checked = 0;
		endfunction

		function int nt_slot(logic [15:0] a);
			logic t;
			t = mirror_vertical ? a[11] : a[10];
			return {t, a[9:0]};
		endfunction

		function int pal_slot(logic [15:0] a);
			logic [4:0] i;
			i = a[4:0];
			if ((i & 5'h13) == 5'h10) begin
				i = i & 5'h0f;
			end
			return i;
		endfunction

		function logic [7:0] vram_fetch(logic [15:0] a);
			logic [13:0] x;
			x = a[13:0];
			if (x <= 14'h1fff) begin
				return pat_mem[x[12:0]];
			end else if (x < 14'h3f00) begin
				return nt_mem[nt_slot(a)];
			end
			return {2'b00, pal_mem[pal_slot(a)]};
		endfunction

		function void vram_store(logic [15:0] a, logic [7:0] d);
			logic [13:0] x;
			x = a[13:0];
			if (x <= 14'h1fff) begin
				pat_mem[x[12:0]] = d;
			end else if (x < 14'h3f00) begin
				nt_mem[nt_slot(a)] = d;
			end else begin
				pal_mem[pal_slot(a)] = d[5:0];
			end
		endfunction

		function void step_address();
			current_address = current_address + (control_bits[2] ? 16'd32 : 16'd1);
		endfunction

		function void note_request(logic op, logic [2:0] ri, logic [7:0] d);
			logic [7:0] r;
			r = 8'h00;
			if (op == vrpva_pkg::OpWrite) begin
				bus_latch = d;
				case (ri)
					vrpva_pkg::RegControl: begin
						control_bits = d;
						staged_address[11:10] = d[1:0];
					end
					vrpva_pkg::RegMask: mask_bits = d;
					vrpva_pkg::RegSprAddr: sprite_pointer = d;
					vrpva_pkg::RegSprData: begin
						sprite_mem[sprite_pointer] = d;
						sprite_pointer = sprite_pointer + 8'd1;
					end
					vrpva_pkg::RegScroll: begin
						if (!write_toggle) begin
							fine_scroll_x = d[2:0];
							staged_address[4:0] = d[7:3];
							write_toggle = 1;
						end else begin
							staged_address = (staged_address & 16'h8c1f)
								| ({13'd0, d[2:0]} << 12) | ({11'd0, d[7:3]} << 5);
							write_toggle = 0;
						end
					end
					vrpva_pkg::RegAddr: begin
						if (!write_toggle) begin
							staged_address = {2'b00, d[5:0], staged_address[7:0]};
							write_toggle = 1;
						end else begin
							staged_address[7:0] = d;
							current_address = staged_address;
							write_toggle = 0;
						end
					end
					vrpva_pkg::RegData: begin
						vram_store(current_address, d);
						step_address();
					end
					default: ;
				endcase
			end else begin
				case (ri)
					vrpva_pkg::RegStatus: begin
						r = {status_top_bits, bus_latch[4:0]};
						status_top_bits[2] = 1'b0;
						write_toggle = 0;
					end
					vrpva_pkg::RegSprData: r = sprite_mem[sprite_pointer];
					vrpva_pkg::RegData: begin
						if (current_address[13:0] >= 14'h3f00) begin
							r = vram_fetch(current_address);
							read_buffer = vram_fetch(current_address & 16'h2fff);
						end else begin
							r = read_buffer;
							read_buffer = vram_fetch(current_address);
						end
						step_address();
					end
					default: r = bus_latch;
				endcase
				bus_latch = r;
			end
			expected_bytes.push_back(r);
		endfunction

		task check_response(logic [7:0] got);
			logic [7:0] want;
			if (expected_bytes.size() == 0) begin
				report_mismatch("response with no request pending", got, 8'h00);
				return;
			end
			want = expected_bytes.pop_front();
			checked++;
			if (got !== want) begin
				report_mismatch("read_data", got, want);
			end
		endtask

		task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
			errors++;
			$display("mismatch %0t: %s got %02h want %02h", $time, what, got, want);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	vrpva_req_if req ();
	vrpva_rsp_if rsp ();

	port_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int sent;

	video_register_port_vram_access_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			sb.check_response(rsp.read_data);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_mirror(bit v);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 2'd0;
		pwdata <= {31'd0, v};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.mirror_vertical = v;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send_request(logic op, logic [2:0] ri, logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.op <= op;
		req.reg_index <= ri;
		req.write_data <= d;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, ri, d);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (sb.expected_bytes.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_address(logic [15:0] a);
		send_request(vrpva_pkg::OpRead, vrpva_pkg::RegStatus, 8'h00);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegAddr, a[15:8]);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegAddr, a[7:0]);
	endtask

	task automatic random_requests(int n);
		int kind;
		logic [15:0] a;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(9);
			if (kind < 2) begin
				case ($urandom_range(3))
					0: a = 16'($urandom_range(16'h1fff));
					1: a = 16'(16'h2000 + $urandom_range(16'h1eff));
					2: a = 16'(16'h3f00 + $urandom_range(8'hff));
					default: a = 16'($urandom);
				endcase
				set_address(a);
				repeat ($urandom_range(1, 4))
					send_request(1'($urandom_range(1)), vrpva_pkg::RegData, 8'($urandom));
			end else if (kind < 4) begin
				send_request(1'($urandom_range(1)), vrpva_pkg::RegData, 8'($urandom));
			end else if (kind < 5) begin
				send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegSprAddr, 8'($urandom));
				send_request(1'($urandom_range(1)), vrpva_pkg::RegSprData, 8'($urandom));
			end else begin
				send_request(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		req.valid = 0;
		req.op = 0;
		req.reg_index = 0;
		req.write_data = 0;
		rsp.ready = 0;
		sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: every register read and written, extremes and aliases
		for (int r = 0; r < 8; r++) send_request(vrpva_pkg::OpRead, r[2:0], 8'h00);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegControl, 8'hff);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegMask, 8'hff);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegStatus, 8'hff);
		send_request(vrpva_pkg::OpRead, vrpva_pkg::RegStatus, 8'h00);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegSprAddr, 8'hff);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegSprData, 8'h5a);
		send_request(vrpva_pkg::OpRead, vrpva_pkg::RegSprData, 8'h00);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegScroll, 8'hff);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegScroll, 8'hff);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegAddr, 8'hff);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegAddr, 8'h10);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegData, 8'hff);
		send_request(vrpva_pkg::OpRead, vrpva_pkg::RegData, 8'h00);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegControl, 8'h00);
		set_address(16'h3f10);
		send_request(vrpva_pkg::OpWrite, vrpva_pkg::RegData, 8'h2a);
		set_address(16'h3f00);
		send_request(vrpva_pkg::OpRead, vrpva_pkg::RegData, 8'h00);
		set_address(16'hffff);
		send_request(vrpva_pkg::OpRead, vrpva_pkg::RegData, 8'h00);
		drain();

		send_idle_pct = 18;
		recv_idle_pct = 72;
		random_requests(150);
		drain();
		write_mirror(1);
		send_idle_pct = 72;
		recv_idle_pct = 18;
		random_requests(150);
		drain();
		write_mirror(0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_requests(120);
		drain();
		write_mirror(1);
		random_requests(80);
		drain();

		$display("covered %0d requests, %0d responses checked, both mirroring modes",
			sent, sb.checked);
		if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
